@@ hdl/bmsbi_pkg.sv @@
package bmsbi_pkg;

    // frame geometry
    localparam int MAX_FRAME_BYTES = 64;
    localparam int MIN_FRAME_LEN   = 29;
    localparam int INDEX_W         = 8;

    // header codes
    localparam logic [7:0] START_BYTE   = 8'hDD;
    localparam logic [7:0] CMD_BASIC    = 8'h03;
    localparam logic [7:0] STATUS_OK    = 8'h00;
    localparam logic [7:0] MIN_LEN_BYTE = 8'h19;

    // percent divider: dividend is residual * 100, at most 23 bits
    localparam int DIVIDEND_W = 23;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);
    localparam logic [6:0] PCT_SCALE = 7'd100;

    localparam logic [16:0] TEMP_OFFSET = 17'd2731;

    // controller to datapath
    typedef struct packed {
        logic byte_accept;
        logic div_load;
        logic div_step;
        logic result_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_last;
    } dp_status_t;

    // one parsed result
    typedef struct packed {
        logic               discharge_fet_on;
        logic               charge_fet_on;
        logic signed [16:0] temperature;
        logic        [15:0] balance_bits;
        logic signed [8:0]  charge_pct;
        logic        [15:0] cap_full;
        logic        [15:0] cap_remaining;
        logic        [15:0] current_magnitude;
        logic signed [1:0]  current_direction;
        logic        [15:0] batt_voltage;
    } result_t;

endpackage

@@ hdl/bmsbi_datapath.sv @@
module bmsbi_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bmsbi_pkg::ctrl_cmd_t cmd,
    output bmsbi_pkg::dp_status_t status,
    input  logic [7:0]           rx_byte,
    input  logic                 frame_end,
    output logic                 frame_valid,
    output bmsbi_pkg::result_t   result
);
    import bmsbi_pkg::*;

    // byte offsets within the frame
    localparam logic [INDEX_W-1:0] POS_START   = 8'd0;
    localparam logic [INDEX_W-1:0] POS_CMD     = 8'd1;
    localparam logic [INDEX_W-1:0] POS_STATUS  = 8'd2;
    localparam logic [INDEX_W-1:0] POS_LEN     = 8'd3;
    localparam logic [INDEX_W-1:0] POS_VOLT_HI = 8'd4;
    localparam logic [INDEX_W-1:0] POS_VOLT_LO = 8'd5;
    localparam logic [INDEX_W-1:0] POS_CUR_HI  = 8'd6;
    localparam logic [INDEX_W-1:0] POS_CUR_LO  = 8'd7;
    localparam logic [INDEX_W-1:0] POS_RES_HI  = 8'd8;
    localparam logic [INDEX_W-1:0] POS_RES_LO  = 8'd9;
    localparam logic [INDEX_W-1:0] POS_NOM_HI  = 8'd10;
    localparam logic [INDEX_W-1:0] POS_NOM_LO  = 8'd11;
    localparam logic [INDEX_W-1:0] POS_BAL_HI  = 8'd16;
    localparam logic [INDEX_W-1:0] POS_BAL_LO  = 8'd17;
    localparam logic [INDEX_W-1:0] POS_FET     = 8'd24;
    localparam logic [INDEX_W-1:0] POS_TEMP_HI = 8'd27;
    localparam logic [INDEX_W-1:0] POS_TEMP_LO = 8'd28;

    logic [INDEX_W-1:0] byte_index_reg, byte_index_next;
    logic               header_good_reg, header_good_next;
    logic               valid_reg;
    logic [15:0]        voltage_word_reg, current_word_reg, residual_word_reg;
    logic [15:0]        nominal_word_reg, balance_word_reg, temp_word_reg;
    logic [7:0]         fet_byte_reg;
    logic               in_range;

    logic [DIVIDEND_W-1:0] dividend_reg, quotient_reg;
    logic [15:0]           rem_reg;
    logic [DIV_CNT_W-1:0]  div_cnt_reg;
    logic [16:0]           rem_shift;
    logic                  rem_fits;

    result_t result_reg, result_next;
    logic    frame_valid_reg;

    assign in_range = byte_index_reg < INDEX_W'(MAX_FRAME_BYTES);

    always_comb
    begin
        header_good_next = header_good_reg;
        byte_index_next  = byte_index_reg;
        if (in_range)
        begin
            byte_index_next = byte_index_reg + 1'b1;
            unique case (byte_index_reg)
                POS_START:  if (rx_byte != START_BYTE)  header_good_next = 1'b0;
                POS_CMD:    if (rx_byte != CMD_BASIC)   header_good_next = 1'b0;
                POS_STATUS: if (rx_byte != STATUS_OK)   header_good_next = 1'b0;
                POS_LEN:    if (rx_byte < MIN_LEN_BYTE) header_good_next = 1'b0;
                default:    ;
            endcase
        end
    end

    // frame counting and header check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg  <= '0;
            header_good_reg <= 1'b1;
            valid_reg       <= 1'b0;
        end
        else if (cmd.byte_accept)
        begin
            if (frame_end)
            begin
                valid_reg       <= header_good_next &&
                                   (byte_index_next >= INDEX_W'(MIN_FRAME_LEN));
                byte_index_reg  <= '0;
                header_good_reg <= 1'b1;
            end
            else
            begin
                byte_index_reg  <= byte_index_next;
                header_good_reg <= header_good_next;
            end
        end
    end

    // big-endian field capture
    always_ff @(posedge clk)
    begin
        if (cmd.byte_accept && in_range)
        begin
            unique case (byte_index_reg)
                POS_VOLT_HI: voltage_word_reg[15:8]  <= rx_byte;
                POS_VOLT_LO: voltage_word_reg[7:0]   <= rx_byte;
                POS_CUR_HI:  current_word_reg[15:8]  <= rx_byte;
                POS_CUR_LO:  current_word_reg[7:0]   <= rx_byte;
                POS_RES_HI:  residual_word_reg[15:8] <= rx_byte;
                POS_RES_LO:  residual_word_reg[7:0]  <= rx_byte;
                POS_NOM_HI:  nominal_word_reg[15:8]  <= rx_byte;
                POS_NOM_LO:  nominal_word_reg[7:0]   <= rx_byte;
                POS_BAL_HI:  balance_word_reg[15:8]  <= rx_byte;
                POS_BAL_LO:  balance_word_reg[7:0]   <= rx_byte;
                POS_FET:     fet_byte_reg            <= rx_byte;
                POS_TEMP_HI: temp_word_reg[15:8]     <= rx_byte;
                POS_TEMP_LO: temp_word_reg[7:0]      <= rx_byte;
                default:     ;
            endcase
        end
    end

    // restoring divider, one quotient bit a cycle
    assign rem_shift = {rem_reg, dividend_reg[DIVIDEND_W-1]};
    assign rem_fits  = rem_shift >= {1'b0, nominal_word_reg};
    assign status.div_last = div_cnt_reg == DIV_CNT_W'(DIVIDEND_W - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_cnt_reg <= '0;
        else if (cmd.div_load)
            div_cnt_reg <= '0;
        else if (cmd.div_step)
            div_cnt_reg <= div_cnt_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            dividend_reg <= DIVIDEND_W'(residual_word_reg) * DIVIDEND_W'(PCT_SCALE);
            quotient_reg <= '0;
            rem_reg      <= '0;
        end
        else if (cmd.div_step)
        begin
            dividend_reg <= {dividend_reg[DIVIDEND_W-2:0], 1'b0};
            quotient_reg <= {quotient_reg[DIVIDEND_W-2:0], rem_fits};
            rem_reg      <= rem_fits ? 16'(rem_shift - {1'b0, nominal_word_reg})
                                     : rem_shift[15:0];
        end
    end

    // result formatting, all zero for an invalid frame
    always_comb
    begin
        result_next = '0;
        if (valid_reg)
        begin
            result_next.batt_voltage = voltage_word_reg;
            if (current_word_reg == 16'd0)
            begin
                result_next.current_direction = 2'sd0;
                result_next.current_magnitude = 16'd0;
            end
            else if (current_word_reg[15])
            begin
                result_next.current_direction = -2'sd1;
                result_next.current_magnitude = ~current_word_reg + 16'd1;
            end
            else
            begin
                result_next.current_direction = 2'sd1;
                result_next.current_magnitude = current_word_reg;
            end
            result_next.cap_remaining = residual_word_reg;
            result_next.cap_full      = nominal_word_reg;
            if (nominal_word_reg == 16'd0)
                result_next.charge_pct = -9'sd1;
            else if (quotient_reg > DIVIDEND_W'(255))
                result_next.charge_pct = 9'sd255;
            else
                result_next.charge_pct = $signed({1'b0, quotient_reg[7:0]});
            result_next.balance_bits     = balance_word_reg;
            result_next.temperature      = $signed({1'b0, temp_word_reg} - TEMP_OFFSET);
            result_next.charge_fet_on    = fet_byte_reg[0];
            result_next.discharge_fet_on = fet_byte_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            result_reg      <= result_next;
            frame_valid_reg <= valid_reg;
        end
    end

    assign result      = result_reg;
    assign frame_valid = frame_valid_reg;

endmodule

@@ hdl/bmsbi_ctrl.sv @@
module bmsbi_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_last,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output bmsbi_pkg::ctrl_cmd_t  cmd,
    input  bmsbi_pkg::dp_status_t status
);
    import bmsbi_pkg::*;

    typedef enum logic [2:0] {
        ST_RECEIVE,
        ST_LOAD,
        ST_DIVIDE,
        ST_FORMAT,
        ST_RESULT
    } state_t;

    state_t state_reg, state_next;
    logic   in_ready_reg, in_ready_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next       = state_reg;
        in_ready_next    = in_ready_reg;
        out_valid_next   = out_valid_reg;
        cmd              = '0;
        cmd.byte_accept  = in_ready_reg && in_valid;
        unique case (state_reg)
            ST_RECEIVE:
            begin
                if (in_valid && in_last)
                begin
                    state_next    = ST_LOAD;
                    in_ready_next = 1'b0;
                end
            end
            ST_LOAD:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.div_last)
                    state_next = ST_FORMAT;
            end
            ST_FORMAT:
            begin
                cmd.result_load = 1'b1;
                state_next      = ST_RESULT;
                out_valid_next  = 1'b1;
            end
            ST_RESULT:
            begin
                if (out_ready)
                begin
                    state_next     = ST_RECEIVE;
                    out_valid_next = 1'b0;
                    in_ready_next  = 1'b1;
                end
            end
            default:
            begin
                state_next     = ST_RECEIVE;
                out_valid_next = 1'b0;
                in_ready_next  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RECEIVE;
            in_ready_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_ready_reg  <= in_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = in_ready_reg;
    assign out_valid = out_valid_reg;

endmodule

@@ hdl/bms_basic_info_frame_parser.sv @@
// after the transfer of the last byte, m_tvalid rises once the load, 23 divide steps and
// format have run; the result then holds until it is taken
// throughput: one byte per cycle within a frame; after each frame end s_tready stays low
// through the bit-serial percent divide and until the result is taken
// reset: rst_n is asynchronous, active low; clears byte count and handshake state, sets header flag
module bms_basic_info_frame_parser
(
    input  logic         clk,
    input  logic         rst_n,
    // byte stream in
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] rx_byte
    input  logic         s_tlast,   // frame_end
    // parsed result out
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] batt_voltage, [17:16] current_direction, [33:18] current_magnitude,
    // [49:34] cap_remaining, [65:50] cap_full, [74:66] charge_pct,
    // [90:75] balance_bits, [107:91] temperature, [108] charge_fet_on,
    // [109] discharge_fet_on, [111:110] zero
    output logic [111:0] m_tdata,
    output logic [0:0]   m_tuser    // [0] frame_valid
);
    import bmsbi_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    result_t    result;
    logic       frame_valid;

    // sequencing: receive bytes, run the divider, present the result
    bmsbi_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd),
        .status    (status)
    );

    // byte counting, header check, field capture, percent divide
    bmsbi_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .rx_byte     (s_tdata),
        .frame_end   (s_tlast),
        .frame_valid (frame_valid),
        .result      (result)
    );

    // result struct packs lowest field first, pad to whole bytes
    assign m_tdata    = {2'b00, result};
    assign m_tuser[0] = frame_valid;

endmodule
